FILE: hdl/adnp_pkg.sv
// Shared constants and tables for the ASCII decimal number parser.
// Character codes, mode, status and register index codes, range bounds.
// No dependencies.
`default_nettype none

package adnp_pkg;

   localparam int ValueWidth      = 64;
   localparam int MaxFracDigits   = 9;
   localparam int FracCountWidth  = 4;
   localparam int PowWidth        = 30;

   // character codes
   localparam logic [7:0] CharSpace = 8'd32;
   localparam logic [7:0] CharDel   = 8'd127;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharPoint = 8'h2E;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   // number_mode codes
   localparam logic [1:0] MODE_SIGNED   = 2'd0;
   localparam logic [1:0] MODE_UNSIGNED = 2'd1;
   localparam logic [1:0] MODE_DECIMAL  = 2'd2;

   // parse_status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA  = 2'd1;
   localparam logic [1:0] STATUS_NAN      = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // register indexes
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 4;
   localparam logic [CsrIndexWidth-1:0] CSR_NUMBER_MODE     = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FRACTION_DIGITS = 1'd1;

   // magnitude bounds, value range of ValueWidth bits
   localparam logic [63:0] LimUnsigned = 64'((65'd1 << ValueWidth) - 65'd1);
   localparam logic [63:0] LimPositive = 64'((65'd1 << (ValueWidth - 1)) - 65'd1);
   localparam logic [63:0] LimNegative = 64'(65'd1 << (ValueWidth - 1));

   // powers of ten for the fraction scaling
   localparam logic [PowWidth-1:0] Pow10Table [0:MaxFracDigits] = '{
      30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
      30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
   };

endpackage

`default_nettype wire

FILE: hdl/ascii_decimal_number_parser_top.sv
// ASCII decimal number parser, top level.
// Byte-at-a-time parse state machine followed by a scaling pipeline.
// Depends on adnp_pkg.
//
//  - req channel: one transfer per character. req_tdata carries the byte,
//    req_tuser set means end of data (byte ignored) and closes the number.
//  - rsp channel: one transfer per finished number. rsp_tdata is the value
//    (two's complement in signed modes, scaled by 10^fraction_digits in
//    decimal mode), rsp_tuser the status: ok, no data, not a number,
//    overflow (value saturated to the range bound).
//  - csr port: csr_we writes csr_wdata into register csr_index
//    (0 number_mode, 1 fraction_digits). Changes apply from the next byte.
//  - Throughput: one byte per cycle when not stalled; the multiply-by-ten
//    accumulate is a single shift-add and compare on the accumulator.
//  - Pipeline: the byte that ends the number passes the registered stages
//    capture, 2 x 32 bit multiply, sum, saturate and out before rsp_tvalid rises.
//  - Stalls: each stage advances when the next one is empty or moving, so
//    a stalled rsp side fills the pipe and then drops req_tready.
//  - Reset: synchronous, active high; parser back to skipping whitespace,
//    pipeline emptied, number_mode 0 and fraction_digits 3.
`default_nettype none

module ascii_decimal_number_parser_top
   import adnp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [7:0]               req_tdata,   // [7:0] text_byte
   input  wire logic                     req_tuser,   // [0] end_of_data

   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [63:0]              rsp_tdata,   // [63:0] number_value
   output      logic [1:0]               rsp_tuser,   // [1:0] parse_status

   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_SIGN,
      PH_INT,
      PH_POINT,
      PH_FRAC
   } phase_type;

   // capture stage: everything finish needs
   typedef struct packed {
      logic [63:0]               mag;
      logic [FracCountWidth-1:0] scale;
      logic [63:0]               lim;
      logic                      neg;
      logic                      ovf;
      logic [1:0]                status;
   } cap_type;

   typedef struct packed {
      logic [61:0] prod_lo;
      logic [61:0] prod_hi;
      logic [63:0] lim;
      logic        neg;
      logic        ovf;
      logic [1:0]  status;
   } mul_type;

   typedef struct packed {
      logic [93:0] sum;
      logic [63:0] lim;
      logic        neg;
      logic        ovf;
      logic [1:0]  status;
   } sum_type;

   typedef struct packed {
      logic [63:0] mag;
      logic        neg;
      logic [1:0]  status;
   } sat_type;

   // ---------------- configuration ----------------
   logic [1:0]                mode_ff;
   logic [CsrDataWidth-1:0]   frac_digits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SIGNED;
         frac_digits_ff <= 4'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUMBER_MODE:     mode_ff        <= csr_wdata[1:0];
            CSR_FRACTION_DIGITS: frac_digits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- parse state ----------------
   phase_type                 phase_ff, phase_in;
   logic                      neg_ff, neg_in;
   logic [63:0]               acc_ff, acc_in;
   logic [FracCountWidth-1:0] cnt_ff, cnt_in;
   logic                      ovf_ff, ovf_in;
   // accumulator value at each fraction count, for truncation at the end
   logic [63:0]               snap_ff [0:MaxFracDigits];

   logic                      req_fire;
   logic                      cap_ready;

   logic                      mode_uns, mode_dec, neg_eff;
   logic [63:0]               lim;
   logic [FracCountWidth-1:0] kept;
   logic                      is_digit;
   logic [3:0]                digit_val;
   logic [67:0]               acc_x10;
   logic [67:0]               push_cand;
   logic                      push_over;
   logic [63:0]               push_acc;

   logic                      emit;
   logic                      emit_finish;
   logic [1:0]                emit_status;
   logic                      do_push;

   logic [FracCountWidth-1:0] fin_m;
   cap_type                   cap_new;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = cap_ready;

   assign mode_uns = (mode_ff == MODE_UNSIGNED);
   assign mode_dec = (mode_ff == MODE_DECIMAL);
   assign neg_eff  = neg_ff && !mode_uns;
   assign lim      = mode_uns ? LimUnsigned : (neg_eff ? LimNegative : LimPositive);
   assign kept     = !mode_dec ? '0 :
                     (frac_digits_ff > FracCountWidth'(MaxFracDigits)) ?
                     FracCountWidth'(MaxFracDigits) : frac_digits_ff;

   assign is_digit  = (req_tdata >= CharZero) && (req_tdata <= CharNine);
   assign digit_val = is_digit ? req_tdata[3:0] : 4'd0;

   // acc*10 + d, saturating at the bound
   assign acc_x10   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0};
   assign push_cand = acc_x10 + 68'(digit_val);
   assign push_over = ovf_ff || (push_cand > {4'b0000, lim});
   assign push_acc  = push_over ? lim : push_cand[63:0];

   always_comb begin
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      emit        = 1'b0;
      emit_finish = 1'b0;
      emit_status = STATUS_OK;
      do_push     = 1'b0;

      if (req_tuser) begin
         emit = 1'b1;
         unique case (phase_ff)
            PH_SKIP: emit_status = STATUS_NO_DATA;
            PH_SIGN: emit_status = STATUS_NAN;
            default: emit_finish = 1'b1;
         endcase
      end else begin
         unique case (phase_ff) inside
            PH_SKIP: begin
               if ((req_tdata <= CharSpace) || (req_tdata == CharDel)) begin
                  phase_in = PH_SKIP;
               end else if ((req_tdata == CharMinus) || (req_tdata == CharPlus)) begin
                  neg_in   = (req_tdata == CharMinus);
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  do_push  = 1'b1;
                  phase_in = PH_INT;
               end else begin
                  emit        = 1'b1;
                  emit_status = STATUS_NAN;
               end
            end
            PH_SIGN: begin
               if (is_digit) begin
                  do_push  = 1'b1;
                  phase_in = PH_INT;
               end else begin
                  emit        = 1'b1;
                  emit_status = STATUS_NAN;
               end
            end
            PH_INT: begin
               if (is_digit) begin
                  do_push = 1'b1;
               end else if ((req_tdata == CharPoint) && mode_dec) begin
                  phase_in = PH_POINT;
               end else begin
                  emit        = 1'b1;
                  emit_finish = 1'b1;
               end
            end
            PH_POINT, PH_FRAC: begin
               if (is_digit) begin
                  phase_in = PH_FRAC;
                  if (cnt_ff < kept) begin
                     do_push = 1'b1;
                     cnt_in  = cnt_ff + FracCountWidth'(1);
                  end
               end else begin
                  emit        = 1'b1;
                  emit_finish = 1'b1;
               end
            end
            default: begin
               emit        = 1'b1;
               emit_status = STATUS_NAN;
            end
         endcase
      end

      acc_in = do_push ? push_acc  : acc_ff;
      ovf_in = do_push ? push_over : ovf_ff;

      // a result closes the number in progress
      if (emit) begin
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         acc_in   = '0;
         cnt_in   = '0;
         ovf_in   = 1'b0;
      end
   end

   // finish: truncate to the kept digits, then scale by the missing ones
   assign fin_m = (cnt_ff < kept) ? cnt_ff : kept;

   always_comb begin
      cap_new = '0;
      cap_new.status = emit_status;
      if (emit_finish) begin
         cap_new.mag   = snap_ff[fin_m];
         cap_new.scale = kept - fin_m;
         cap_new.lim   = lim;
         cap_new.neg   = neg_eff;
         cap_new.ovf   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
      if (req_fire) begin
         snap_ff[cnt_in] <= acc_in;
      end
   end

   // ---------------- result pipeline ----------------
   logic    cap_valid_ff, mul_valid_ff, sum_valid_ff, sat_valid_ff, rsp_valid_ff;
   cap_type cap_ff;
   mul_type mul_ff, mul_in;
   sum_type sum_ff, sum_in;
   sat_type sat_ff, sat_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff;

   logic mul_ready, sum_ready, sat_ready, out_ready;
   logic [PowWidth-1:0] pow;
   logic                sat_big, sat_ovf;

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign sat_ready = !sat_valid_ff || out_ready;
   assign sum_ready = !sum_valid_ff || sat_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign cap_ready = !cap_valid_ff || mul_ready;

   // multiply, in two 32 bit halves
   assign pow = Pow10Table[cap_ff.scale];
   always_comb begin
      mul_in.prod_lo = 62'(cap_ff.mag[31:0])  * 62'(pow);
      mul_in.prod_hi = 62'(cap_ff.mag[63:32]) * 62'(pow);
      mul_in.lim     = cap_ff.lim;
      mul_in.neg     = cap_ff.neg;
      mul_in.ovf     = cap_ff.ovf;
      mul_in.status  = cap_ff.status;
   end

   always_comb begin
      sum_in.sum    = {mul_ff.prod_hi, 32'd0} + {32'd0, mul_ff.prod_lo};
      sum_in.lim    = mul_ff.lim;
      sum_in.neg    = mul_ff.neg;
      sum_in.ovf    = mul_ff.ovf;
      sum_in.status = mul_ff.status;
   end

   // saturate against the bound
   assign sat_big = sum_ff.sum > {30'd0, sum_ff.lim};
   assign sat_ovf = sum_ff.ovf || sat_big;
   always_comb begin
      sat_in.mag    = sat_ovf ? sum_ff.lim : sum_ff.sum[63:0];
      sat_in.neg    = sum_ff.neg;
      sat_in.status = sat_ovf ? STATUS_OVERFLOW : sum_ff.status;
   end

   assign rsp_data_in = sat_ff.neg ? (64'd0 - sat_ff.mag) : sat_ff.mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         sat_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cap_ready) cap_valid_ff <= req_fire && emit;
         if (mul_ready) mul_valid_ff <= cap_valid_ff;
         if (sum_ready) sum_valid_ff <= mul_valid_ff;
         if (sat_ready) sat_valid_ff <= sum_valid_ff;
         if (out_ready) rsp_valid_ff <= sat_valid_ff;
      end
      if (cap_ready) cap_ff <= cap_new;
      if (mul_ready) mul_ff <= mul_in;
      if (sum_ready) sum_ff <= sum_in;
      if (sat_ready) sat_ff <= sat_in;
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= sat_ff.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- assertions ----------------
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FracCountWidth'(MaxFracDigits))
      else $error("fraction count beyond maximum");

   a_skip_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (acc_ff == '0 && cnt_ff == '0 && !ovf_ff && !neg_ff))
      else $error("parse state not cleared while skipping");

   a_cnt_phase: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (phase_ff == PH_FRAC))
      else $error("fraction digits counted outside fraction phase");

   a_nodata_capture: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && phase_ff == PH_SKIP) |=>
      (cap_valid_ff && cap_ff.status == STATUS_NO_DATA))
      else $error("end of data while skipping did not give no-data result");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_NO_DATA || rsp_tuser == STATUS_NAN)) |->
      (rsp_tdata == 64'd0))
      else $error("nonzero value with no-data or not-a-number status");

endmodule

`default_nettype wire
